### hdl/vmmio_pkg.sv
// Shared types and constants for the VirtIO MMIO register block.
// No dependencies.
package vmmio_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_USED  = 2'd2,
        CMD_FATAL = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ID = 2'd0;
    localparam logic [1:0] CFG_VENDOR_ID = 2'd1;
    localparam logic [1:0] CFG_FEATURES  = 2'd2;
    localparam logic [1:0] CFG_CFG_BYTES = 2'd3;

    // control register offsets (word aligned, low 8 bits)
    localparam logic [7:0] OFF_MAGIC        = 8'h00;
    localparam logic [7:0] OFF_VERSION      = 8'h04;
    localparam logic [7:0] OFF_DEVICE_ID    = 8'h08;
    localparam logic [7:0] OFF_VENDOR_ID    = 8'h0c;
    localparam logic [7:0] OFF_DEV_FEAT     = 8'h10;
    localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'h14;
    localparam logic [7:0] OFF_DRV_FEAT     = 8'h20;
    localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'h24;
    localparam logic [7:0] OFF_QUEUE_SEL    = 8'h30;
    localparam logic [7:0] OFF_QUEUE_MAX    = 8'h34;
    localparam logic [7:0] OFF_QUEUE_NUM    = 8'h38;
    localparam logic [7:0] OFF_QUEUE_READY  = 8'h44;
    localparam logic [7:0] OFF_QUEUE_NOTIFY = 8'h50;
    localparam logic [7:0] OFF_INT_STATUS   = 8'h60;
    localparam logic [7:0] OFF_INT_ACK      = 8'h64;
    localparam logic [7:0] OFF_STATUS       = 8'h70;
    localparam logic [7:0] OFF_DESC_LO      = 8'h80;
    localparam logic [7:0] OFF_DESC_HI      = 8'h84;
    localparam logic [7:0] OFF_AVAIL_LO     = 8'h90;
    localparam logic [7:0] OFF_AVAIL_HI     = 8'h94;
    localparam logic [7:0] OFF_USED_LO      = 8'ha0;
    localparam logic [7:0] OFF_USED_HI      = 8'ha4;
    localparam logic [7:0] OFF_SHM_SEL      = 8'hac;
    localparam logic [7:0] OFF_SHM_LEN_LO   = 8'hb0;
    localparam logic [7:0] OFF_SHM_LEN_HI   = 8'hb4;
    localparam logic [7:0] OFF_SHM_BASE_LO  = 8'hb8;
    localparam logic [7:0] OFF_SHM_BASE_HI  = 8'hbc;
    localparam logic [7:0] OFF_CFG_GEN      = 8'hfc;

    localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE = 32'd2;
    localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
    localparam logic [63:0] VERSION1_BIT  = 64'h1_0000_0000;

    localparam logic [31:0] ST_DRV_READY     = 32'd4;
    localparam logic [31:0] ST_FEAT_ACCEPTED = 32'd8;
    localparam logic [31:0] ST_NEEDS_RESET   = 32'd64;
    localparam logic [31:0] INT_USED         = 32'd1;
    localparam logic [31:0] INT_CFG          = 32'd2;

    // request to the config space store
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [7:0]  addr;   // byte offset within config space
        logic [3:0]  be;
        logic [31:0] wdata;  // already placed on its byte lanes
    } t_cs_req;

endpackage

### hdl/vmmio_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmmio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/vmmio_cfg_space.sv
// Byte-wide device config space: four byte-lane RAMs plus per-byte valid bits.
// Depends on vmmio_pkg and vmmio_ram.
module vmmio_cfg_space
    import vmmio_pkg::*;
#(
    parameter int CONFIG_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cs_req     i_req,
    output logic [31:0] o_rdata   // little-endian word, unwritten bytes read zero
);
    localparam int WORDS = (CONFIG_BYTES + 3) / 4;
    localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int VW    = 1 << AW;

    logic [AW-1:0]      word_addr;
    logic [VW*4-1:0]    r_vld;
    logic [3:0]         r_rvld;
    logic [7:0]         lane_q [4];

    assign word_addr = i_req.addr[AW+1:2];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        vmmio_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_req.wr && i_req.be[l]),
            .i_waddr (word_addr),
            .i_wdata (i_req.wdata[8*l +: 8]),
            .i_re    (i_req.rd),
            .i_raddr (word_addr),
            .o_rdata (lane_q[l])
        );
        assign o_rdata[8*l +: 8] = r_rvld[l] ? lane_q[l] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= '0;
        end else begin
            if (i_req.wr) begin
                for (int l = 0; l < 4; l++) begin
                    if (i_req.be[l]) begin
                        r_vld[{word_addr, 2'(l)}] <= 1'b1;
                    end
                end
            end
            if (i_req.rd) begin
                r_rvld <= r_vld[{word_addr, 2'b00} +: 4];
            end
        end
    end
endmodule

### hdl/virtio_mmio_register_block_top.sv
// VirtIO MMIO transport register block, top level.
// A result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result side takes each result; the config space RAM read is registered.
// Output register decouples the sides: input ready = output empty or taken.
// Synchronous active-low reset clears all transport state and the config space
// (byte valid bits); no clearing pass is needed. Depends on vmmio_pkg, vmmio_cfg_space.
module virtio_mmio_register_block_top
    import vmmio_pkg::*;
#(
    parameter int QUEUE_COUNT    = 2,
    parameter int QUEUE_SIZE_MAX = 128,
    parameter int CONFIG_BYTES   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [8:0]  i_reg_offset,
    input  logic [1:0]  i_size_log2,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_access_ok,
    output logic        o_serve_interrupt,
    output logic        o_irq_pending,
    output logic        o_notify_valid,
    output logic [2:0]  o_notify_queue,
    output logic        o_device_ok_pulse,
    output logic        o_device_reset_pulse
);
    localparam int QIW = QUEUE_COUNT > 1 ? $clog2(QUEUE_COUNT) : 1;
    localparam logic [31:0] QCNT = 32'(QUEUE_COUNT);
    localparam logic [31:0] QMAX = 32'(QUEUE_SIZE_MAX);
    localparam logic [8:0]  CFG_LIMIT = 9'(CONFIG_BYTES);

    // configuration registers
    logic [31:0] r_dev_id, r_vendor;
    logic [63:0] r_offered;
    logic [8:0]  r_cfg_bytes;

    // transport state
    logic [31:0] r_status, n_status;
    logic        r_drv_ok, n_drv_ok;
    logic [63:0] r_drv_feat, n_drv_feat;
    logic [31:0] r_dev_sel, n_dev_sel;
    logic [31:0] r_drv_sel, n_drv_sel;
    logic [31:0] r_qsel, n_qsel;
    logic [31:0] r_int, n_int;
    logic [31:0] r_gen, n_gen;
    logic [QUEUE_COUNT-1:0] r_qready, n_qready;

    // output stage
    logic        r_ov;
    logic        r_cs_rd, n_cs_rd;
    logic [1:0]  r_boff;
    logic [1:0]  r_lg;
    logic [31:0] r_rdata, n_rdata;
    logic        r_ok, n_ok;
    logic        r_serve, n_serve;
    logic        r_irq;
    logic        r_nvalid, n_nvalid;
    logic [2:0]  r_nq, n_nq;
    logic        r_okp, n_okp;
    logic        r_rstp, n_rstp;

    logic        accept;
    t_cmd        cmd;
    logic [63:0] feat_now;
    logic        qok;
    logic [7:0]  off;
    logic [31:0] val;
    logic [31:0] enabling;
    t_cs_req     cs_req;
    logic [31:0] cs_word;
    logic [9:0]  cs_end;
    logic [8:0]  cs_limit;
    logic        cs_ok;
    logic [31:0] cs_shift;

    assign o_ready  = !r_ov || i_ready;
    assign accept   = i_valid && o_ready;
    assign cmd      = t_cmd'(i_command);
    assign off      = i_reg_offset[7:0];
    assign val      = i_write_data;
    assign feat_now = r_offered | VERSION1_BIT;
    assign qok      = r_qsel < QCNT;
    assign enabling = (r_status ^ val) & val;

    // config space shape check: aligned 1/2/4 bytes ending inside the usable size
    assign cs_limit = (r_cfg_bytes > CFG_LIMIT) ? CFG_LIMIT : r_cfg_bytes;
    assign cs_end   = {2'b00, off} + (10'd1 << i_size_log2);
    assign cs_ok    = (i_size_log2 != 2'd3)
                   && !(i_size_log2 == 2'd1 && off[0])
                   && !(i_size_log2 == 2'd2 && off[1:0] != 2'b00)
                   && (cs_end <= {1'b0, cs_limit});
    assign cs_shift = val << {off[1:0], 3'b000};

    always_comb begin
        cs_req.rd    = accept && i_reg_offset[8] && cmd == CMD_READ && cs_ok;
        cs_req.wr    = accept && i_reg_offset[8] && cmd == CMD_WRITE && cs_ok;
        cs_req.addr  = off;
        cs_req.wdata = cs_shift;
        case (i_size_log2)
            2'd0:    cs_req.be = 4'b0001 << off[1:0];
            2'd1:    cs_req.be = 4'b0011 << off[1:0];
            default: cs_req.be = 4'b1111;
        endcase
    end

    vmmio_cfg_space #(.CONFIG_BYTES(CONFIG_BYTES)) u_cfg_space (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cs_req),
        .o_rdata (cs_word)
    );

    // decode and state update for one word
    always_comb begin
        n_status   = r_status;
        n_drv_ok   = r_drv_ok;
        n_drv_feat = r_drv_feat;
        n_dev_sel  = r_dev_sel;
        n_drv_sel  = r_drv_sel;
        n_qsel     = r_qsel;
        n_int      = r_int;
        n_gen      = r_gen;
        n_qready   = r_qready;
        n_cs_rd    = 1'b0;
        n_rdata    = '0;
        n_ok       = 1'b0;
        n_serve    = 1'b0;
        n_nvalid   = 1'b0;
        n_nq       = '0;
        n_okp      = 1'b0;
        n_rstp     = 1'b0;

        if (cmd == CMD_USED) begin
            n_ok = 1'b1;
            if (r_drv_ok) n_int = r_int | INT_USED;
        end else if (cmd == CMD_FATAL) begin
            n_ok     = 1'b1;
            n_status = r_status | ST_NEEDS_RESET;
            n_gen    = r_gen + 32'd1;
            if (r_drv_ok) n_int = r_int | INT_CFG;
        end else if (i_reg_offset[8]) begin
            n_ok    = cs_ok;
            n_cs_rd = cs_ok && cmd == CMD_READ;
        end else if (off[1:0] != 2'b00 || i_size_log2 != 2'd2) begin
            n_ok = 1'b0;
        end else if (cmd == CMD_READ) begin
            n_ok = 1'b1;
            case (off)
                OFF_MAGIC:     n_rdata = MAGIC_VALUE;
                OFF_VERSION:   n_rdata = VERSION_VALUE;
                OFF_DEVICE_ID: n_rdata = r_dev_id;
                OFF_VENDOR_ID: n_rdata = r_vendor;
                OFF_DEV_FEAT: begin
                    if (r_dev_sel == 32'd0)      n_rdata = feat_now[31:0];
                    else if (r_dev_sel == 32'd1) n_rdata = feat_now[63:32];
                end
                OFF_QUEUE_MAX:   n_rdata = qok ? QMAX : 32'd0;
                OFF_QUEUE_READY: n_rdata = qok ? {31'd0, r_qready[r_qsel[QIW-1:0]]} : 32'd0;
                OFF_INT_STATUS:  n_rdata = r_int;
                OFF_STATUS:      n_rdata = r_status;
                OFF_CFG_GEN:     n_rdata = r_gen;
                OFF_SHM_LEN_LO, OFF_SHM_LEN_HI,
                OFF_SHM_BASE_LO, OFF_SHM_BASE_HI: n_rdata = ALL_ONES;
                default: n_ok = 1'b0;
            endcase
        end else begin
            n_ok = 1'b1;
            case (off)
                OFF_DEV_FEAT_SEL: n_dev_sel = val;
                OFF_DRV_FEAT: begin
                    if (r_drv_sel == 32'd0)      n_drv_feat[31:0]  = val;
                    else if (r_drv_sel == 32'd1) n_drv_feat[63:32] = val;
                end
                OFF_DRV_FEAT_SEL: n_drv_sel = val;
                OFF_QUEUE_SEL:    n_qsel = val;
                // queue size has no read path; a write is accepted and its value is discarded
                OFF_QUEUE_NUM: ;
                OFF_QUEUE_READY: begin
                    if (qok) n_qready[r_qsel[QIW-1:0]] = (val == 32'd1);
                end
                OFF_QUEUE_NOTIFY: begin
                    if (val < QCNT && r_drv_ok && r_qready[val[QIW-1:0]]) begin
                        n_nvalid = 1'b1;
                        n_nq     = val[2:0];
                    end
                    n_serve = r_int != 32'd0;
                end
                OFF_INT_ACK: begin
                    n_int   = r_int & ~val;
                    n_serve = n_int != 32'd0;
                end
                OFF_STATUS: begin
                    if (val == 32'd0) begin
                        // device reset: config generation and config space survive
                        n_status   = '0;
                        n_drv_ok   = 1'b0;
                        n_drv_feat = '0;
                        n_dev_sel  = '0;
                        n_drv_sel  = '0;
                        n_qsel     = '0;
                        n_int      = '0;
                        n_qready   = '0;
                        n_rstp     = 1'b1;
                    end else if ((enabling & ST_FEAT_ACCEPTED) != 32'd0
                                 && r_drv_feat != feat_now) begin
                        // feature mismatch: refused silently
                        n_serve = 1'b0;
                    end else begin
                        n_status = val;
                        if ((enabling & ST_DRV_READY) != 32'd0) begin
                            if ((r_status & ST_NEEDS_RESET) != 32'd0) begin
                                n_int = r_int | INT_CFG;
                            end else begin
                                n_drv_ok = 1'b1;
                                n_okp    = 1'b1;
                            end
                        end
                        n_serve = n_int != 32'd0;
                    end
                end
                // ring addresses and shm select: taken, nothing downstream reads them
                OFF_DESC_LO, OFF_DESC_HI, OFF_AVAIL_LO, OFF_AVAIL_HI,
                OFF_USED_LO, OFF_USED_HI, OFF_SHM_SEL: ;
                default: n_ok = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id    <= '0;
            r_vendor    <= '0;
            r_offered   <= VERSION1_BIT;
            r_cfg_bytes <= '0;
            r_status    <= '0;
            r_drv_ok    <= 1'b0;
            r_drv_feat  <= '0;
            r_dev_sel   <= '0;
            r_drv_sel   <= '0;
            r_qsel      <= '0;
            r_int       <= '0;
            r_gen       <= '0;
            r_qready    <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEVICE_ID: r_dev_id    <= i_cfg_wdata[31:0];
                    CFG_VENDOR_ID: r_vendor    <= i_cfg_wdata[31:0];
                    CFG_FEATURES:  r_offered   <= i_cfg_wdata;
                    CFG_CFG_BYTES: r_cfg_bytes <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_status   <= n_status;
                r_drv_ok   <= n_drv_ok;
                r_drv_feat <= n_drv_feat;
                r_dev_sel  <= n_dev_sel;
                r_drv_sel  <= n_drv_sel;
                r_qsel     <= n_qsel;
                r_int      <= n_int;
                r_gen      <= n_gen;
                r_qready   <= n_qready;
                r_ov       <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cs_rd  <= n_cs_rd;
            r_boff   <= off[1:0];
            r_lg     <= i_size_log2;
            r_rdata  <= n_rdata;
            r_ok     <= n_ok;
            r_serve  <= n_serve;
            r_irq    <= n_int != 32'd0;
            r_nvalid <= n_nvalid;
            r_nq     <= n_nq;
            r_okp    <= n_okp;
            r_rstp   <= n_rstp;
        end
    end

    // config read: pick the bytes out of the registered word
    logic [31:0] cs_align_word;
    logic [31:0] cs_rd_data;
    assign cs_align_word = cs_word >> {r_boff, 3'b000};
    always_comb begin
        case (r_lg)
            2'd0:    cs_rd_data = {24'd0, cs_align_word[7:0]};
            2'd1:    cs_rd_data = {16'd0, cs_align_word[15:0]};
            default: cs_rd_data = cs_align_word;
        endcase
    end

    assign o_valid              = r_ov;
    assign o_read_data          = r_cs_rd ? cs_rd_data : r_rdata;
    assign o_access_ok          = r_ok;
    assign o_serve_interrupt    = r_serve;
    assign o_irq_pending        = r_irq;
    assign o_notify_valid       = r_nvalid;
    assign o_notify_queue       = r_nq;
    assign o_device_ok_pulse    = r_okp;
    assign o_device_reset_pulse = r_rstp;

    a_reset_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_device_reset_pulse |-> !o_irq_pending)
        else $error("device reset left interrupt pending");
    a_notify_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_notify_valid |-> o_access_ok && !o_device_reset_pulse)
        else $error("notify on refused access");
    a_notify_q_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_notify_valid |-> o_notify_queue == 3'd0)
        else $error("stray notify queue index");
    a_serve_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_serve_interrupt |-> o_irq_pending)
        else $error("serve without pending interrupt");
    a_rdata_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_data != 32'd0 |-> o_access_ok)
        else $error("data returned on refused access");
endmodule
